>>> src/bnc_pkg.sv
// ----------------------------------------------------------------------------
// bnc_pkg: shared types and constants of the bracket nesting checker
// Bracket kinds, line status codes, character decode and score limits.
// ----------------------------------------------------------------------------
`default_nettype none

package bnc_pkg;

    // default number of stack cells
    localparam int STACK_DEPTH_DEF = 64;

    // field widths
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;
    localparam int KIND_W   = 2;
    localparam int DEPTH_W  = 7;
    localparam int SCORE_W  = 63;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 80;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 7'd127;
    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;

    // bracket kinds
    localparam t_kind KIND_ROUND  = 2'd0;
    localparam t_kind KIND_SQUARE = 2'd1;
    localparam t_kind KIND_CURLY  = 2'd2;
    localparam t_kind KIND_ANGLE  = 2'd3;

    // line status codes
    localparam t_status ST_COMPLETE   = 2'd0;
    localparam t_status ST_CORRUPTED  = 2'd1;
    localparam t_status ST_INCOMPLETE = 2'd2;
    localparam t_status ST_OVERFLOW   = 2'd3;

    // bracket characters
    localparam logic [CHAR_W-1:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_OPEN_ANGLE   = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_CLOSE_ANGLE  = 8'h3E;

    // decoded bracket: hit flag and kind
    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_bracket;

    // stack shift control broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

    function automatic t_bracket decode_opener(input logic [CHAR_W-1:0] c);
        t_bracket b;
        b = '{hit: 1'b1, kind: KIND_ROUND};
        unique case (c)
            CH_OPEN_ROUND:  b.kind = KIND_ROUND;
            CH_OPEN_SQUARE: b.kind = KIND_SQUARE;
            CH_OPEN_CURLY:  b.kind = KIND_CURLY;
            CH_OPEN_ANGLE:  b.kind = KIND_ANGLE;
            default:        b.hit  = 1'b0;
        endcase
        return b;
    endfunction

    function automatic t_bracket decode_closer(input logic [CHAR_W-1:0] c);
        t_bracket b;
        b = '{hit: 1'b1, kind: KIND_ROUND};
        unique case (c)
            CH_CLOSE_ROUND:  b.kind = KIND_ROUND;
            CH_CLOSE_SQUARE: b.kind = KIND_SQUARE;
            CH_CLOSE_CURLY:  b.kind = KIND_CURLY;
            CH_CLOSE_ANGLE:  b.kind = KIND_ANGLE;
            default:         b.hit  = 1'b0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> src/bnc_cell.sv
// ----------------------------------------------------------------------------
// bnc_cell: one entry of the shifting opener stack
// Takes the kind from the cell above on a push and from the cell below on a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module bnc_cell (
    input  wire                       i_clk,
    input  wire bnc_pkg::t_shift_ctl  i_ctl,
    input  wire bnc_pkg::t_kind       i_from_above,
    input  wire bnc_pkg::t_kind       i_from_below,
    output bnc_pkg::t_kind            o_kind
);

    bnc_pkg::t_kind r_kind;
    bnc_pkg::t_kind n_kind;

    // shift toward the bottom on push, toward the top on pop
    always_comb begin
        n_kind = r_kind;
        if (i_ctl.push) begin
            n_kind = i_from_above;
        end else if (i_ctl.pop) begin
            n_kind = i_from_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
    end

    assign o_kind = r_kind;

endmodule

`default_nettype wire

>>> src/bracket_nesting_checker_core.sv
// ----------------------------------------------------------------------------
// bracket_nesting_checker_core: per-line bracket nesting check
// Keeps open brackets in a chain of shifting cells and reports one result
// per line with status, bad closer kind, open depth and completion score.
// ----------------------------------------------------------------------------
//
// channel   dir  signals                       transaction
// s (char)  in   tvalid/tready/tdata/tlast     one character; tlast ends the line
// m (line)  out  tvalid/tready/tdata           one result per line
//
// The top of the stack is always cell 0.
// A line ending incomplete with N open brackets unwinds one cell per cycle
// through the score unit, during which no character is taken.
// Other lines deliver their result into the output register right away.
// Reset is synchronous; it clears the depth count, flags and output valid.
// While a result waits in the output register and the sink is not ready,
// ready stays low for every character; the last unwind step waits as well.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_nesting_checker_core #(
    parameter int STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    input  wire  [bnc_pkg::IN_DATA_W-1:0]     i_s_tdata,  // [7:0] char_code
    input  wire                               i_s_tlast,  // line_end
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    // [1:0] line_status, [3:2] bad_closer_kind, [10:4] open_depth,
    // [73:11] completion_score, [79:74] zero
    output logic [bnc_pkg::OUT_DATA_W-1:0]    o_m_tdata
);

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int DW  = (SPW > bnc_pkg::DEPTH_W) ? SPW : bnc_pkg::DEPTH_W;
    localparam int TW  = bnc_pkg::SCORE_W + 3;
    localparam int PADW = bnc_pkg::OUT_DATA_W - bnc_pkg::STATUS_W - bnc_pkg::KIND_W
                        - bnc_pkg::DEPTH_W - bnc_pkg::SCORE_W;

    typedef enum logic [1:0] {
        S_RUN    = 2'b01,
        S_UNWIND = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [SPW-1:0] r_sp, n_sp;
    logic r_cor, n_cor;
    logic r_ovf, n_ovf;
    bnc_pkg::t_kind r_bad, n_bad;
    logic [bnc_pkg::DEPTH_W-1:0] r_depth, n_depth;
    logic [bnc_pkg::SCORE_W-1:0] r_score, n_score;

    logic r_out_valid, n_out_valid;
    bnc_pkg::t_status r_out_status, n_out_status;
    bnc_pkg::t_kind r_out_bad, n_out_bad;
    logic [bnc_pkg::DEPTH_W-1:0] r_out_depth, n_out_depth;
    logic [bnc_pkg::SCORE_W-1:0] r_out_score, n_out_score;

    bnc_pkg::t_kind kinds [STACK_DEPTH];
    bnc_pkg::t_shift_ctl shift_ctl;
    bnc_pkg::t_bracket opener, closer;

    logic out_free, accept, active, stack_full, match;
    logic do_push, do_pop, set_ovf, set_cor, unwind_go;
    logic fin_cor, fin_ovf;
    bnc_pkg::t_kind fin_bad;
    logic [SPW-1:0] fin_sp;
    logic [DW-1:0] sp_ext;
    logic [bnc_pkg::DEPTH_W-1:0] fin_depth;
    logic [2:0] pop_val;
    logic [TW-1:0] score_sum;
    logic [bnc_pkg::SCORE_W-1:0] score_step;

    // chain of stack cells, cell 0 holds the top
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        bnc_pkg::t_kind above, below;
        if (g == 0) begin : g_top
            assign above = opener.kind;
        end else begin : g_mid_a
            assign above = kinds[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_bot
            assign below = bnc_pkg::KIND_ROUND;
        end else begin : g_mid_b
            assign below = kinds[g+1];
        end
        bnc_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (shift_ctl),
            .i_from_above (above),
            .i_from_below (below),
            .o_kind       (kinds[g])
        );
    end

    // handshake
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_RUN) && out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    // character decode and match against the top cell
    assign opener     = bnc_pkg::decode_opener(i_s_tdata[bnc_pkg::CHAR_W-1:0]);
    assign closer     = bnc_pkg::decode_closer(i_s_tdata[bnc_pkg::CHAR_W-1:0]);
    assign active     = !r_cor && !r_ovf;
    assign stack_full = (r_sp == SPW'(STACK_DEPTH));
    assign match      = (r_sp != '0) && (kinds[0] == closer.kind);
    assign do_push    = accept && active && opener.hit && !stack_full;
    assign set_ovf    = accept && active && opener.hit && stack_full;
    assign do_pop     = accept && active && closer.hit && match;
    assign set_cor    = accept && active && closer.hit && !match;

    // line state after this character
    assign fin_cor = r_cor || set_cor;
    assign fin_ovf = r_ovf || set_ovf;
    assign fin_bad = set_cor ? closer.kind : r_bad;
    assign fin_sp  = do_push ? r_sp + SPW'(1) : (do_pop ? r_sp - SPW'(1) : r_sp);

    // open depth saturates at the field maximum
    assign sp_ext    = DW'(fin_sp);
    assign fin_depth = (sp_ext > DW'(bnc_pkg::DEPTH_MAX)) ? bnc_pkg::DEPTH_MAX
                                                          : sp_ext[bnc_pkg::DEPTH_W-1:0];

    // score unit: score*5 + value, saturating
    assign unwind_go  = (r_state == S_UNWIND) && ((r_sp != SPW'(1)) || out_free);
    assign pop_val    = {1'b0, kinds[0]} + 3'd1;
    assign score_sum  = TW'({r_score, 2'b00}) + TW'(r_score) + TW'(pop_val);
    assign score_step = (score_sum > TW'(bnc_pkg::SCORE_MAX)) ? bnc_pkg::SCORE_MAX
                                                              : score_sum[bnc_pkg::SCORE_W-1:0];

    assign shift_ctl.push = do_push;
    assign shift_ctl.pop  = do_pop || unwind_go;

    // line control and result load
    always_comb begin
        n_state      = r_state;
        n_sp         = r_sp;
        n_cor        = r_cor;
        n_ovf        = r_ovf;
        n_bad        = r_bad;
        n_depth      = r_depth;
        n_score      = r_score;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_bad    = r_out_bad;
        n_out_depth  = r_out_depth;
        n_out_score  = r_out_score;
        unique case (r_state)
            S_RUN: begin
                if (accept) begin
                    n_sp  = fin_sp;
                    n_cor = fin_cor;
                    n_ovf = fin_ovf;
                    n_bad = fin_bad;
                    if (i_s_tlast) begin
                        n_cor = 1'b0;
                        n_ovf = 1'b0;
                        n_bad = bnc_pkg::KIND_ROUND;
                        n_depth = fin_depth;
                        n_score = '0;
                        if (!fin_cor && !fin_ovf && (fin_sp != '0)) begin
                            n_state = S_UNWIND;
                        end else begin
                            n_sp         = '0;
                            n_out_valid  = 1'b1;
                            n_out_bad    = bnc_pkg::KIND_ROUND;
                            n_out_depth  = fin_depth;
                            n_out_score  = '0;
                            if (fin_cor) begin
                                n_out_status = bnc_pkg::ST_CORRUPTED;
                                n_out_bad    = fin_bad;
                            end else if (fin_ovf) begin
                                n_out_status = bnc_pkg::ST_OVERFLOW;
                            end else begin
                                n_out_status = bnc_pkg::ST_COMPLETE;
                            end
                        end
                    end
                end
            end
            S_UNWIND: begin
                if (unwind_go) begin
                    n_sp    = r_sp - SPW'(1);
                    n_score = score_step;
                    if (r_sp == SPW'(1)) begin
                        n_state      = S_RUN;
                        n_out_valid  = 1'b1;
                        n_out_status = bnc_pkg::ST_INCOMPLETE;
                        n_out_bad    = bnc_pkg::KIND_ROUND;
                        n_out_depth  = r_depth;
                        n_out_score  = score_step;
                    end
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_sp        <= '0;
            r_cor       <= 1'b0;
            r_ovf       <= 1'b0;
            r_bad       <= bnc_pkg::KIND_ROUND;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_cor       <= n_cor;
            r_ovf       <= n_ovf;
            r_bad       <= n_bad;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_depth      <= n_depth;
        r_score      <= n_score;
        r_out_status <= n_out_status;
        r_out_bad    <= n_out_bad;
        r_out_depth  <= n_out_depth;
        r_out_score  <= n_out_score;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PADW{1'b0}}, r_out_score, r_out_depth, r_out_bad, r_out_status};

endmodule

`default_nettype wire
